// ===== design/eroq_pkg.sv =====
// shared types, constants and the ordering test of the elevator request queue
`default_nettype none
package eroq_pkg;

   localparam int NUM_FLOORS  = 4;
   localparam int MAX_ENTRIES = 16;
   localparam int FLOOR_W     = 2;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // one stored request
   typedef struct packed {
      logic               up;
      logic               cab;
      logic [FLOOR_W-1:0] floor;
   } entry_type;

   // one result item
   typedef struct packed {
      logic               lamp_valid;
      logic [FLOOR_W-1:0] lamp_floor;
      logic               lamp_cab;
      logic               lamp_up;
      logic               lamp_on;
      logic               accepted;
      logic               head_valid;
      logic [FLOOR_W-1:0] head_floor;
      logic [CNT_W-1:0]   entry_total;
      logic               last;
   } rsp_type;

   // result offered by the sequencer to the output register
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } emit_type;

   // true when the new request is served before the visited entry
   function automatic logic goes_before(input entry_type cur,
                                        input logic [FLOOR_W-1:0] hf,
                                        input logic [FLOOR_W-1:0] nf,
                                        input logic ni,
                                        input logic nu,
                                        input logic [FLOOR_W-1:0] prev);
      logic res;
      res = 1'b0;
      if (cur.floor == nf) begin
         res = 1'b0;
      end else if (hf == nf && prev > hf && (ni || !nu)) begin
         res = 1'b1;
      end else if (hf == nf && prev < hf && (ni || nu)) begin
         res = 1'b1;
      end else if ((ni && cur.cab) || !ni) begin
         res = (prev > cur.floor && prev > nf && nf >= cur.floor && (!nu || ni)) ||
               (prev < cur.floor && prev < nf && nf <= cur.floor && (nu || ni));
      end else if (prev > nf && prev > cur.floor && cur.floor >= nf && !cur.up) begin
         res = 1'b0;
      end else if (prev < nf && prev < cur.floor && cur.floor <= nf && cur.up) begin
         res = 1'b0;
      end else begin
         res = 1'b1;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== design/elevator_request_ordering_queue.sv =====
// Elevator request ordering queue, top level.
// Input channel req_*: one item is an add request (tuser 0) or a clear of
// all requests at a floor (tuser 1). The table of up to 16 requests lives in
// a one-port-read, one-port-write memory with registered read data.
// Result channel rsp_*: each item gives one result, or for a clear one
// result per removed entry; tlast marks the final result of an item.
// Order of work: an add scans every stored entry, then shifts the tail down
// one place and writes the new entry; a duplicate add is dropped after the
// scan. A clear makes two passes over the table, or one when nothing
// matches. One item is at work at a time, and the next is taken once its
// results are in the output register. Reset empties the table at once (no
// clearing pass: entries past the count are never read). When the receiver
// stalls, the held result waits in the output register and the table walk
// stops on the next entry that would report.
`default_nettype none
module elevator_request_ordering_queue (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [1:0] req_floor, [2] cab_call, [3] dir_up, [5:4] car_floor, [7:6] zero
   input  wire  [7:0]  req_tdata,
   // [0] op
   input  wire  [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [1:0] lamp_floor, [2] lamp_cab, [3] lamp_up, [4] lamp_on, [5] accepted,
   // [6] head_valid, [8:7] head_floor, [13:9] entry_total, [15:14] zero
   output logic [15:0] rsp_tdata,
   // [0] lamp_valid
   output logic [0:0]  rsp_tuser,
   output logic        rsp_tlast
);

   eroq_pkg::emit_type                emit;
   eroq_pkg::rsp_type                 rsp_ff;
   logic                              rsp_valid_ff;
   logic                              out_free;
   logic                              wr_en;
   logic [eroq_pkg::IDX_W-1:0]        wr_addr;
   eroq_pkg::entry_type               wr_data;
   logic [eroq_pkg::IDX_W-1:0]        rd_addr;
   eroq_pkg::entry_type               rd_data;
   logic [1:0]                        unused_pad;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign unused_pad = req_tdata[7:6];

   eroq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_op    (req_tuser[0]),
      .in_floor (req_tdata[1:0]),
      .in_cab   (req_tdata[2]),
      .in_up    (req_tdata[3]),
      .in_car   (req_tdata[5:4]),
      .out_free (out_free),
      .emit     (emit),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   eroq_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit.valid) begin
         rsp_ff <= emit.data;
      end
   end

   // pack result item
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tuser  = rsp_ff.lamp_valid;
   assign rsp_tdata  = {2'b00, rsp_ff.entry_total, rsp_ff.head_floor, rsp_ff.head_valid,
                        rsp_ff.accepted, rsp_ff.lamp_on, rsp_ff.lamp_up, rsp_ff.lamp_cab,
                        rsp_ff.lamp_floor};

endmodule
`default_nettype wire

// ===== design/eroq_ram.sv =====
// request table memory, one write port and one registered read port
`default_nettype none
module eroq_ram (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [eroq_pkg::IDX_W-1:0] wr_addr,
   input  eroq_pkg::entry_type      wr_data,
   input  wire  [eroq_pkg::IDX_W-1:0] rd_addr,
   output eroq_pkg::entry_type      rd_data
);

   eroq_pkg::entry_type mem [eroq_pkg::MAX_ENTRIES];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== design/eroq_ctrl.sv =====
// sequencer that scans, shifts and compacts the request table
`default_nettype none
module eroq_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        in_valid,
   output logic                       in_ready,
   input  wire                        in_op,
   input  wire  [eroq_pkg::FLOOR_W-1:0] in_floor,
   input  wire                        in_cab,
   input  wire                        in_up,
   input  wire  [eroq_pkg::FLOOR_W-1:0] in_car,
   input  wire                        out_free,
   output eroq_pkg::emit_type         emit,
   output logic                       wr_en,
   output logic [eroq_pkg::IDX_W-1:0] wr_addr,
   output eroq_pkg::entry_type        wr_data,
   output logic [eroq_pkg::IDX_W-1:0] rd_addr,
   input  eroq_pkg::entry_type        rd_data
);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_SCAN_RD  = 10'b0000000010,
      S_SCAN_EV  = 10'b0000000100,
      S_SHIFT_RD = 10'b0000001000,
      S_SHIFT_WR = 10'b0000010000,
      S_PUT      = 10'b0000100000,
      S_CNT_RD   = 10'b0001000000,
      S_CNT_EV   = 10'b0010000000,
      S_CLR_RD   = 10'b0100000000,
      S_CLR_EV   = 10'b1000000000
   } state_type;

   state_type                     state_ff;
   logic                          resp_ff;
   logic [eroq_pkg::FLOOR_W-1:0]  rf_ff;
   logic                          ni_ff;
   logic                          nu_ff;
   logic [eroq_pkg::FLOOR_W-1:0]  prev_ff;
   logic [eroq_pkg::IDX_W-1:0]    idx_ff;
   logic [eroq_pkg::IDX_W-1:0]    pos_ff;
   logic [eroq_pkg::IDX_W-1:0]    wp_ff;
   logic                          found_ff;
   logic                          dup_ff;
   logic                          seen_ff;
   logic [eroq_pkg::CNT_W-1:0]    cnt_ff;
   logic [eroq_pkg::CNT_W-1:0]    lim_ff;
   logic [eroq_pkg::CNT_W-1:0]    match_ff;
   logic [eroq_pkg::CNT_W-1:0]    sent_ff;
   logic [eroq_pkg::FLOOR_W-1:0]  hf_ff;
   logic [eroq_pkg::FLOOR_W-1:0]  nhf_ff;
   logic                          acc_ff;
   logic                          lamp_ff;

   logic                          is_end;
   logic                          is_dup;
   logic                          ahead;
   logic                          hit;
   logic                          floor_ok;
   logic                          clr_last;

   assign floor_ok = int'(in_floor) < eroq_pkg::NUM_FLOORS;
   assign is_end   = (eroq_pkg::CNT_W'(idx_ff) + eroq_pkg::CNT_W'(1)) == lim_ff;
   assign is_dup   = rd_data.floor == rf_ff && rd_data.cab == ni_ff &&
                     (ni_ff || rd_data.up == nu_ff);
   assign ahead    = eroq_pkg::goes_before(rd_data, hf_ff, rf_ff, ni_ff, nu_ff, prev_ff);
   assign hit      = rd_data.floor == rf_ff;
   assign clr_last = (sent_ff + eroq_pkg::CNT_W'(1)) == match_ff;
   assign in_ready = state_ff == S_IDLE && !resp_ff;
   assign rd_addr  = idx_ff;

   // memory writes and results
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_data;
      emit    = '0;
      emit.data.accepted    = acc_ff;
      emit.data.head_valid  = cnt_ff != '0;
      emit.data.head_floor  = (cnt_ff != '0) ? hf_ff : '0;
      emit.data.entry_total = cnt_ff;
      unique case (state_ff)
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff + eroq_pkg::IDX_W'(1);
         end
         S_PUT: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data.floor = rf_ff;
            wr_data.cab   = ni_ff;
            wr_data.up    = nu_ff;
         end
         S_CLR_EV: begin
            wr_en   = !hit;
            wr_addr = wp_ff;
            emit.valid           = hit;
            emit.data.lamp_valid = 1'b1;
            emit.data.lamp_floor = rf_ff;
            emit.data.lamp_cab   = rd_data.cab;
            emit.data.lamp_up    = !rd_data.cab && rd_data.up;
            emit.data.last       = clr_last;
         end
         default: begin
            emit.valid           = resp_ff;
            emit.data.lamp_valid = lamp_ff;
            emit.data.lamp_floor = lamp_ff ? rf_ff : '0;
            emit.data.lamp_cab   = lamp_ff && ni_ff;
            emit.data.lamp_up    = lamp_ff && !ni_ff && nu_ff;
            emit.data.lamp_on    = lamp_ff;
            emit.data.last       = 1'b1;
         end
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         resp_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (resp_ff && out_free) begin
                  resp_ff <= 1'b0;
               end else if (in_valid && in_ready) begin
                  rf_ff    <= in_floor;
                  ni_ff    <= in_cab;
                  nu_ff    <= in_up;
                  prev_ff  <= in_car;
                  idx_ff   <= '0;
                  pos_ff   <= '0;
                  wp_ff    <= '0;
                  found_ff <= 1'b0;
                  dup_ff   <= 1'b0;
                  seen_ff  <= 1'b0;
                  match_ff <= '0;
                  sent_ff  <= '0;
                  lim_ff   <= cnt_ff;
                  acc_ff   <= 1'b0;
                  lamp_ff  <= 1'b0;
                  if (!floor_ok) begin
                     resp_ff <= 1'b1;
                  end else if (in_op == eroq_pkg::OP_ADD) begin
                     if (int'(cnt_ff) >= eroq_pkg::MAX_ENTRIES) begin
                        resp_ff <= 1'b1;
                     end else if (cnt_ff == '0) begin
                        state_ff <= S_PUT;
                     end else begin
                        state_ff <= S_SCAN_RD;
                     end
                  end else if (cnt_ff == '0) begin
                     resp_ff <= 1'b1;
                  end else begin
                     state_ff <= S_CNT_RD;
                  end
               end
            end
            S_SCAN_RD: begin
               state_ff <= S_SCAN_EV;
            end
            // duplicate check and ordering walk in one pass
            S_SCAN_EV: begin
               if (is_dup) begin
                  dup_ff <= 1'b1;
               end
               if (!found_ff && ahead) begin
                  found_ff <= 1'b1;
                  pos_ff   <= idx_ff;
               end
               if (!found_ff) begin
                  prev_ff <= rd_data.floor;
               end
               if (!is_end) begin
                  idx_ff   <= idx_ff + eroq_pkg::IDX_W'(1);
                  state_ff <= S_SCAN_RD;
               end else if (dup_ff || is_dup) begin
                  resp_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else if (!found_ff && !ahead) begin
                  pos_ff   <= eroq_pkg::IDX_W'(lim_ff);
                  state_ff <= S_PUT;
               end else begin
                  state_ff <= S_SHIFT_RD;
               end
            end
            // move entries one place down, from the end toward the slot
            S_SHIFT_RD: begin
               state_ff <= S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
               if (idx_ff == pos_ff) begin
                  state_ff <= S_PUT;
               end else begin
                  idx_ff   <= idx_ff - eroq_pkg::IDX_W'(1);
                  state_ff <= S_SHIFT_RD;
               end
            end
            S_PUT: begin
               cnt_ff  <= cnt_ff + eroq_pkg::CNT_W'(1);
               acc_ff  <= 1'b1;
               lamp_ff <= 1'b1;
               resp_ff <= 1'b1;
               if (pos_ff == '0) begin
                  hf_ff <= rf_ff;
               end
               state_ff <= S_IDLE;
            end
            // first clear pass counts matches and finds the new head
            S_CNT_RD: begin
               state_ff <= S_CNT_EV;
            end
            S_CNT_EV: begin
               if (hit) begin
                  match_ff <= match_ff + eroq_pkg::CNT_W'(1);
               end else if (!seen_ff) begin
                  seen_ff <= 1'b1;
                  nhf_ff  <= rd_data.floor;
               end
               if (!is_end) begin
                  idx_ff   <= idx_ff + eroq_pkg::IDX_W'(1);
                  state_ff <= S_CNT_RD;
               end else if (!hit && match_ff == '0) begin
                  resp_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  if (hit) begin
                     cnt_ff   <= lim_ff - match_ff - eroq_pkg::CNT_W'(1);
                  end else begin
                     cnt_ff   <= lim_ff - match_ff;
                  end
                  if (!seen_ff && !hit) begin
                     hf_ff <= rd_data.floor;
                  end else begin
                     hf_ff <= nhf_ff;
                  end
                  idx_ff   <= '0;
                  state_ff <= S_CLR_RD;
               end
            end
            // second clear pass compacts and reports each removal
            S_CLR_RD: begin
               state_ff <= S_CLR_EV;
            end
            S_CLR_EV: begin
               if (!hit || out_free) begin
                  if (hit) begin
                     sent_ff <= sent_ff + eroq_pkg::CNT_W'(1);
                  end else begin
                     wp_ff <= wp_ff + eroq_pkg::IDX_W'(1);
                  end
                  if (is_end) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + eroq_pkg::IDX_W'(1);
                     state_ff <= S_CLR_RD;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== design/eroq_chk.sv =====
// port checker for the elevator request ordering queue
`default_nettype none
module eroq_chk (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [15:0] rsp_tdata,
   input wire [0:0]  rsp_tuser,
   input wire        rsp_tlast
);

   // head is shown exactly when entries remain
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[6] == (rsp_tdata[13:9] != 5'd0)))
      else $error("head_valid disagrees with entry_total");

   // empty table reports floor zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[6]) |-> rsp_tdata[8:7] == 2'd0)
      else $error("head_floor not zero on empty table");

   // count stays within table size
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[13:9] <= 5'(eroq_pkg::MAX_ENTRIES))
      else $error("entry_total beyond table size");

   // a result without a lamp change is always the only one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> rsp_tlast)
      else $error("empty result not marked last");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind elevator_request_ordering_queue eroq_chk u_eroq_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

// ===== test/testbench.sv =====
// testbench of the elevator request ordering queue: random and directed requests checked item by item
`default_nettype none

// predicts result items from accepted requests and checks the block's results
class lamp_scoreboard;
   logic [1:0] tab_floor [16];
   logic       tab_cab [16];
   logic       tab_up [16];
   int         count;
   logic [15:0] want_data [$];
   logic        want_user [$];
   logic        want_last [$];
   int          errors;

   function new();
      count = 0;
      errors = 0;
   endfunction

   function bit orders_before(int idx, logic [1:0] nf, logic ni, logic nu, logic [1:0] prev);
      logic [1:0] cf;
      logic ci, cu;
      logic [1:0] hf;
      cf = tab_floor[idx];
      ci = tab_cab[idx];
      cu = tab_up[idx];
      hf = tab_floor[0];
      if (cf == nf) return 0;
      if (hf == nf) begin
         if (prev > hf && (ni || !nu)) return 1;
         if (prev < hf && (ni || nu)) return 1;
      end
      if ((ni && ci) || !ni) begin
         if (prev > cf && prev > nf && nf >= cf && (!nu || ni)) return 1;
         if (prev < cf && prev < nf && nf <= cf && (nu || ni)) return 1;
         return 0;
      end
      if (prev > nf && prev > cf && cf >= nf && !cu) return 0;
      if (prev < nf && prev < cf && cf <= nf && cu) return 0;
      return 1;
   endfunction

   // note an accepted request item and queue its expected results
   function void note_request(logic op, logic [7:0] d);
      logic [1:0] rf, car, prev;
      logic ni, nu, acc, dup;
      logic [4:0] lamps [$];
      int pos, w;
      rf = d[1:0];
      ni = d[2];
      nu = d[3];
      car = d[5:4];
      acc = 0;
      if (op == eroq_pkg::OP_ADD) begin
         dup = 0;
         for (int i = 0; i < count; i++)
            if (tab_floor[i] == rf && tab_cab[i] == ni && (ni || tab_up[i] == nu)) dup = 1;
         if (count < 16 && !dup) begin
            pos = count;
            prev = car;
            for (int i = 0; i < count; i++) begin
               if (orders_before(i, rf, ni, nu, prev)) begin
                  pos = i;
                  break;
               end
               prev = tab_floor[i];
            end
            for (int i = count; i > pos; i--) begin
               tab_floor[i] = tab_floor[i-1];
               tab_cab[i] = tab_cab[i-1];
               tab_up[i] = tab_up[i-1];
            end
            tab_floor[pos] = rf;
            tab_cab[pos] = ni;
            tab_up[pos] = nu;
            count++;
            acc = 1;
            lamps.push_back({1'b1, 1'b1, !ni && nu, ni, 1'b0} | 5'b0);
            lamps[0] = {1'b1, (!ni && nu), ni, rf[1], rf[0]};
         end
      end else begin
         w = 0;
         for (int i = 0; i < count; i++) begin
            if (tab_floor[i] == rf) begin
               lamps.push_back({1'b0, (!tab_cab[i] && tab_up[i]), tab_cab[i], rf});
            end else begin
               tab_floor[w] = tab_floor[i];
               tab_cab[w] = tab_cab[i];
               tab_up[w] = tab_up[i];
               w++;
            end
         end
         count = w;
      end
      // lamps entries: [4] on, [3] up, [2] cab, [1:0] floor
      if (lamps.size() == 0) begin
         want_data.push_back(pack(5'b0, acc));
         want_user.push_back(1'b0);
         want_last.push_back(1'b1);
      end else begin
         foreach (lamps[k]) begin
            want_data.push_back(pack(lamps[k], acc));
            want_user.push_back(1'b1);
            want_last.push_back(k == lamps.size() - 1);
         end
      end
   endfunction

   function logic [15:0] pack(logic [4:0] l, logic acc);
      logic [15:0] v;
      v = '0;
      v[4:0] = l;
      v[5] = acc;
      v[6] = count > 0;
      v[8:7] = count > 0 ? tab_floor[0] : 2'd0;
      v[13:9] = count[4:0];
      return v;
   endfunction

   function void check_result(logic [15:0] d, logic u, logic l);
      logic [15:0] ed;
      if (want_data.size() == 0) begin
         $error("unexpected result item %h", d);
         errors++;
         return;
      end
      ed = want_data.pop_front();
      if (ed[1:0] != d[1:0]) begin $error("lamp_floor exp %0d got %0d", ed[1:0], d[1:0]); errors++; end
      if (ed[2] != d[2]) begin $error("lamp_cab exp %0d got %0d", ed[2], d[2]); errors++; end
      if (ed[3] != d[3]) begin $error("lamp_up exp %0d got %0d", ed[3], d[3]); errors++; end
      if (ed[4] != d[4]) begin $error("lamp_on exp %0d got %0d", ed[4], d[4]); errors++; end
      if (ed[5] != d[5]) begin $error("accepted exp %0d got %0d", ed[5], d[5]); errors++; end
      if (ed[6] != d[6]) begin $error("head_valid exp %0d got %0d", ed[6], d[6]); errors++; end
      if (ed[8:7] != d[8:7]) begin $error("head_floor exp %0d got %0d", ed[8:7], d[8:7]); errors++; end
      if (ed[13:9] != d[13:9]) begin $error("entry_total exp %0d got %0d", ed[13:9], d[13:9]); errors++; end
      if (ed[15:14] != d[15:14]) begin $error("pad exp %0d got %0d", ed[15:14], d[15:14]); errors++; end
      ed[0] = want_user.pop_front();
      if (ed[0] != u) begin $error("lamp_valid exp %0d got %0d", ed[0], u); errors++; end
      ed[0] = want_last.pop_front();
      if (ed[0] != l) begin $error("last exp %0d got %0d", ed[0], l); errors++; end
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   wire         req_tready;
   logic [7:0]  req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 0;
   wire  [15:0] rsp_tdata;
   wire  [0:0]  rsp_tuser;
   wire         rsp_tlast;
   int          send_idle = 32;
   int          recv_idle = 48;
   lamp_scoreboard board = new();

   elevator_request_ordering_queue uut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // receiver with random stalls
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tuser[0], rsp_tlast);
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   // send one request item, idling before it at random
   task automatic send_request(logic op, logic [1:0] f, logic cab, logic up, logic [1:0] car);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {2'b00, car, up, cab, f};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(op, {2'b00, car, up, cab, f});
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.want_data.size() != 0) @(posedge clock);
   endtask

   task automatic random_phase(int n);
      logic [1:0] fl;
      for (int i = 0; i < n; i++) begin
         fl = 2'($urandom_range(3));
         if ($urandom_range(99) < 75)
            send_request(eroq_pkg::OP_ADD, fl, 1'($urandom_range(1)), 1'($urandom_range(1)),
                         2'($urandom_range(3)));
         else
            send_request(eroq_pkg::OP_CLEAR, fl, 1'($urandom_range(1)), 1'($urandom_range(1)),
                         2'($urandom_range(3)));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty clear, extremes, duplicates, a twelve-entry table, multi-clear
      send_request(eroq_pkg::OP_CLEAR, 2'd0, 1'b0, 1'b0, 2'd0);
      send_request(eroq_pkg::OP_ADD, 2'd3, 1'b1, 1'b1, 2'd0);
      send_request(eroq_pkg::OP_ADD, 2'd3, 1'b1, 1'b0, 2'd3);
      send_request(eroq_pkg::OP_ADD, 2'd0, 1'b0, 1'b1, 2'd3);
      send_request(eroq_pkg::OP_ADD, 2'd0, 1'b0, 1'b0, 2'd2);
      for (int f = 0; f < 4; f++)
         for (int c = 0; c < 2; c++)
            send_request(eroq_pkg::OP_ADD, 2'(f), 1'(c), 1'b1, 2'd1);
      for (int f = 0; f < 4; f++)
         send_request(eroq_pkg::OP_ADD, 2'(f), 1'b0, 1'b0, 2'd2);
      send_request(eroq_pkg::OP_ADD, 2'd2, 1'b0, 1'b1, 2'd0);
      send_request(eroq_pkg::OP_CLEAR, 2'd3, 1'b1, 1'b1, 2'd3);
      send_request(eroq_pkg::OP_CLEAR, 2'd0, 1'b0, 1'b0, 2'd0);
      // pause until every expected result has come
      drain();
      random_phase(170);
      send_idle = 48;
      recv_idle = 32;
      random_phase(170);
      send_idle = 0;
      recv_idle = 0;
      random_phase(170);
      drain();
      repeat (100) @(posedge clock);
      if (board.errors == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   initial begin
      #2ms;
      $display("testbench: errors");
      $finish;
   end
endmodule
`default_nettype wire
